[design/ral_pkg.sv]
// ----------------------------------------------------------------------------
// ral_pkg: shared types and constants for the resource admission ledger
// Holds the slot count, operation and status codes, register indexes, the
// request and result word layouts and the controller/datapath link types.
// ----------------------------------------------------------------------------
package ral_pkg;

	// Number of instance slots in the table.
	localparam int SLOTS   = 16;
	// Bits needed to walk the slots.
	localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	// Width of the unit accumulator; it can never overflow.
	localparam int ACC_W   = 32 + $clog2(SLOTS + 1);

	// Operation codes.
	localparam logic [2:0] OP_CHECK   = 3'd0;
	localparam logic [2:0] OP_ALLOC   = 3'd1;
	localparam logic [2:0] OP_RELEASE = 3'd2;
	localparam logic [2:0] OP_CLEAR   = 3'd3;
	localparam logic [2:0] OP_USED    = 3'd4;
	localparam logic [2:0] OP_AVAIL   = 3'd5;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_COMPUTE = 2'd2;
	localparam logic [1:0] ST_MEMORY  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_TOTAL_UNITS    = 2'd0;
	localparam logic [1:0] REG_RESERVED_UNITS = 2'd1;
	localparam logic [1:0] REG_MIN_FREE_MEM   = 2'd2;

	// Input word.
	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  slot;
		logic        id_present;
		logic        fps_negative;
		logic [31:0] request_units;
		logic [63:0] request_memory;
		logic [63:0] free_bytes;
	} ral_request_t;

	// Result word.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] unit_count;
	} ral_result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic               load;
		logic               acc_en;
		logic               calc;
		logic               finish;
		logic [SLOT_IW-1:0] idx;
	} ral_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_walk;
	} ral_stat_t;

endpackage

[design/ral_ctrl.sv]
// ----------------------------------------------------------------------------
// ral_ctrl: sequencing controller for the resource admission ledger
// Accepts a word, walks the slot table one entry a cycle and runs the decision
// step when the operation needs the sums, then runs the write-back step.
// ----------------------------------------------------------------------------
module ral_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ral_pkg::ral_stat_t stat,
	output ral_pkg::ral_cmd_t  cmd,
	output logic              busy,
	output logic              done
);

	localparam int SIW = ral_pkg::SLOT_IW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_CALC,
		S_FINISH
	} state_t;

	state_t         state_q;
	logic [SIW-1:0] idx_q;
	logic           done_q;
	logic           last_slot;

	// The walk ends on the last slot.
	assign last_slot = (idx_q == SIW'(ral_pkg::SLOTS - 1));

	// State, walk index and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (start) begin
						state_q <= stat.needs_walk ? S_WALK : S_FINISH;
					end
				end
				S_WALK: begin
					if (last_slot) begin
						state_q <= S_CALC;
					end else begin
						idx_q <= idx_q + SIW'(1);
					end
				end
				S_CALC: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Commands decoded from the state.
	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.acc_en = (state_q == S_WALK);
		cmd.calc   = (state_q == S_CALC);
		cmd.finish = (state_q == S_FINISH);
		cmd.idx    = idx_q;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

[design/ral_dpath.sv]
// ----------------------------------------------------------------------------
// ral_dpath: datapath of the resource admission ledger
// Holds the configuration registers and slot table, sums the units and the
// saturated memory during the walk, and forms the status and unit count.
// ----------------------------------------------------------------------------
module ral_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  ral_pkg::ral_request_t request,
	input  ral_pkg::ral_cmd_t     cmd,
	output ral_pkg::ral_stat_t    stat,
	output ral_pkg::ral_result_t  result
);

	localparam int SIW  = ral_pkg::SLOT_IW;
	localparam int AW   = ral_pkg::ACC_W;
	localparam int NSLT = ral_pkg::SLOTS;

	// Configuration registers.
	logic [31:0] total_units_q;
	logic [31:0] reserved_units_q;
	logic [63:0] min_free_mem_q;

	// Slot table.
	logic [NSLT-1:0] slot_valid_q;
	logic [31:0]     slot_units_q  [NSLT];
	logic [63:0]     slot_memory_q [NSLT];

	// Captured word and accumulators.
	ral_pkg::ral_request_t req_q;
	logic [AW-1:0]         acc_units_q;
	logic [63:0]           acc_mem_q;

	// Decision operands.
	logic [31:0] alloc_q;
	logic [63:0] mem_total_q;
	logic        mem_over_q;
	logic [63:0] mem_limit_q;
	logic        mem_under_q;

	ral_pkg::ral_result_t result_q;

	logic          is_query;
	logic          slot_in_range;
	logic          include_slot;
	logic [64:0]   walk_mem_sum;
	logic [64:0]   req_mem_sum;
	logic [64:0]   free_diff;
	logic [32:0]   alloc_diff;
	logic          units_fail;
	logic          mem_fail;
	logic          invalid;
	logic [AW-1:0] room_units;
	logic [1:0]    status_d;
	logic [31:0]   count_d;
	logic [SIW-1:0] wr_idx;

	// Operations that walk the table.
	always_comb begin
		case (request.operation) inside
			ral_pkg::OP_CHECK, ral_pkg::OP_ALLOC,
			ral_pkg::OP_USED, ral_pkg::OP_AVAIL: stat.needs_walk = 1'b1;
			default:                             stat.needs_walk = 1'b0;
		endcase
	end

	assign is_query      = (req_q.operation == ral_pkg::OP_USED) ||
	                       (req_q.operation == ral_pkg::OP_AVAIL);
	assign slot_in_range = (32'(req_q.slot) < 32'(NSLT));
	assign wr_idx        = SIW'(req_q.slot);

	// Walk step: queries take every valid slot, checks skip the own slot.
	assign include_slot = slot_valid_q[cmd.idx] &&
	                      (is_query || (32'(cmd.idx) != 32'(req_q.slot)));
	assign walk_mem_sum = {1'b0, acc_mem_q} + {1'b0, slot_memory_q[cmd.idx]};

	// Decision operands.
	assign req_mem_sum = {1'b0, acc_mem_q} + {1'b0, req_q.request_memory};
	assign free_diff   = {1'b0, req_q.free_bytes} - {1'b0, min_free_mem_q};
	assign alloc_diff  = {1'b0, total_units_q} - {1'b0, reserved_units_q};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_units_q    <= '0;
			reserved_units_q <= '0;
			min_free_mem_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ral_pkg::REG_TOTAL_UNITS:    total_units_q    <= cfg_data[31:0];
				ral_pkg::REG_RESERVED_UNITS: reserved_units_q <= cfg_data[31:0];
				ral_pkg::REG_MIN_FREE_MEM:   min_free_mem_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Capture, walk accumulation and decision operands.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q       <= request;
			acc_units_q <= '0;
			acc_mem_q   <= '0;
		end else if (cmd.acc_en && include_slot) begin
			acc_units_q <= acc_units_q + AW'(slot_units_q[cmd.idx]);
			acc_mem_q   <= walk_mem_sum[64] ? '1 : walk_mem_sum[63:0];
		end
		if (cmd.calc) begin
			mem_total_q <= req_mem_sum[64] ? '1 : req_mem_sum[63:0];
			mem_over_q  <= req_mem_sum[64];
			mem_limit_q <= free_diff[63:0];
			mem_under_q <= free_diff[64];
		end
		if (cmd.load) begin
			alloc_q <= alloc_diff[32] ? '0 : alloc_diff[31:0];
		end
	end

	// Status and unit count.
	always_comb begin
		invalid    = !req_q.id_present || req_q.fps_negative || !slot_in_range;
		room_units = AW'(alloc_q - req_q.request_units);
		units_fail = (req_q.request_units > alloc_q) || (acc_units_q > room_units);
		mem_fail   = mem_over_q || mem_under_q || (mem_total_q > mem_limit_q);
		status_d   = ral_pkg::ST_OK;
		count_d    = '0;
		case (req_q.operation) inside
			ral_pkg::OP_CHECK, ral_pkg::OP_ALLOC: begin
				if (invalid) begin
					status_d = ral_pkg::ST_INVALID;
				end else if (units_fail) begin
					status_d = ral_pkg::ST_COMPUTE;
				end else if (mem_fail) begin
					status_d = ral_pkg::ST_MEMORY;
				end
			end
			ral_pkg::OP_USED: begin
				count_d = (|acc_units_q[AW-1:32]) ? '1 : acc_units_q[31:0];
			end
			ral_pkg::OP_AVAIL: begin
				if (AW'(alloc_q) > acc_units_q) begin
					count_d = alloc_q - acc_units_q[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.status     <= status_d;
			result_q.unit_count <= count_d;
		end
	end

	// Valid bits: set on a passing allocate, cleared by release and clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (cmd.finish) begin
			if (req_q.operation == ral_pkg::OP_CLEAR) begin
				slot_valid_q <= '0;
			end else if (req_q.operation == ral_pkg::OP_RELEASE &&
			             req_q.id_present && slot_in_range) begin
				slot_valid_q[wr_idx] <= 1'b0;
			end else if (req_q.operation == ral_pkg::OP_ALLOC &&
			             status_d == ral_pkg::ST_OK) begin
				slot_valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	// Slot contents are stored by a passing allocate.
	always_ff @(posedge clk) begin
		if (cmd.finish && req_q.operation == ral_pkg::OP_ALLOC &&
		    status_d == ral_pkg::ST_OK) begin
			slot_units_q[wr_idx]  <= req_q.request_units;
			slot_memory_q[wr_idx] <= req_q.request_memory;
		end
	end

	assign result = result_q;

endmodule

[design/resource_admission_ledger.sv]
// ----------------------------------------------------------------------------
// resource_admission_ledger: admission controller over a table of slots
// Checks, allocates, releases and clears slot entries and answers used and
// available unit queries.
//
//   Channel   Signals                              Handshake
//   input     request (word)                       start & !busy
//   output    result (word)                        done, one cycle, no stall
//   config    cfg_we, cfg_index, cfg_data          cfg_we, immediate
//
// Check, allocate and the two queries walk the slot table one slot a cycle,
// then pass the decision and finish states before the result strobes; the
// next word can be taken in the strobe cycle. Release, clear and unused codes
// go straight to the finish state. busy is high after acceptance until the
// strobe. Reset empties the table and zeroes the configuration; the receiver
// cannot stall results.
// ----------------------------------------------------------------------------
module resource_admission_ledger (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ral_pkg::ral_request_t request,
	output logic                 done,
	output ral_pkg::ral_result_t  result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data
);

	ral_pkg::ral_cmd_t  cmd;
	ral_pkg::ral_stat_t stat;

	// Sequencing controller.
	ral_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Table, accumulators and decision logic.
	ral_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (request),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

[test/tb_resource_admission_ledger.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_resource_admission_ledger: self-checking bench for the admission ledger
// Drives operation words through the start/busy handshake and programs the
// three limit registers between phases. A scoreboard keeps its own slot table
// and limits and predicts the status and unit count of every accepted word.
// ----------------------------------------------------------------------------
module tb_resource_admission_ledger;

	// Codes the block leaves unused; they must answer ok with a zero count.
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	localparam int ITEMS_PER_PHASE = 250;
	localparam int PHASES          = 6;
	localparam int CYCLE_LIMIT     = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	ral_pkg::ral_request_t request;
	logic                  done;
	ral_pkg::ral_result_t  result;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [63:0]           cfg_data;

	// Shape of well-formed random words for the current limit setting.
	bit [31:0] unit_span;
	bit [63:0] phase_min_free;
	int unsigned cycle_count;

	// Scoreboard: a private copy of the slot table and the limits, and the
	// results still owed by the block, oldest first.
	class ledger_scoreboard;
		bit [31:0]            total_units;
		bit [31:0]            reserved_units;
		bit [63:0]            min_free_mem;
		bit                   slot_taken[ral_pkg::SLOTS];
		bit [31:0]            slot_units[ral_pkg::SLOTS];
		bit [63:0]            slot_mem[ral_pkg::SLOTS];
		ral_pkg::ral_result_t owed_q[$];
		int unsigned          mismatches;
		int unsigned          op_count[8];
		int unsigned          status_count[4];

		function new();
			foreach (slot_taken[i]) begin
				slot_taken[i] = 1'b0;
				slot_units[i] = '0;
				slot_mem[i]   = '0;
			end
			total_units    = '0;
			reserved_units = '0;
			min_free_mem   = '0;
			mismatches     = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [63:0] value);
			case (index)
				ral_pkg::REG_TOTAL_UNITS:    total_units    = value[31:0];
				ral_pkg::REG_RESERVED_UNITS: reserved_units = value[31:0];
				ral_pkg::REG_MIN_FREE_MEM:   min_free_mem   = value;
				default: ;
			endcase
		endfunction

		function bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
			return (a > 64'hFFFF_FFFF_FFFF_FFFF - b) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
		endfunction

		// Units that may be handed out: total less reserved, never below zero.
		function bit [63:0] alloc_cap();
			return (total_units > reserved_units) ?
				{32'd0, total_units - reserved_units} : 64'd0;
		endfunction

		// Admission test shared by check and allocate.
		function bit [1:0] admit_status(ral_pkg::ral_request_t w);
			bit [63:0] other_units;
			bit [63:0] other_mem;
			bit [63:0] cap;
			bit [63:0] want_units;
			bit [63:0] mem_total;
			bit        mem_wrap;
			if (!w.id_present || w.fps_negative || w.slot >= ral_pkg::SLOTS) begin
				return ral_pkg::ST_INVALID;
			end
			other_units = '0;
			other_mem   = '0;
			for (int i = 0; i < ral_pkg::SLOTS; i++) begin
				if (slot_taken[i] && i != w.slot) begin
					other_units = sat_sum(other_units, {32'd0, slot_units[i]});
					other_mem   = sat_sum(other_mem, slot_mem[i]);
				end
			end
			cap        = alloc_cap();
			want_units = {32'd0, w.request_units};
			if (want_units > cap || other_units > cap - want_units) begin
				return ral_pkg::ST_COMPUTE;
			end
			mem_wrap  = other_mem > 64'hFFFF_FFFF_FFFF_FFFF - w.request_memory;
			mem_total = mem_wrap ? 64'hFFFF_FFFF_FFFF_FFFF : other_mem + w.request_memory;
			if (mem_wrap || w.free_bytes < min_free_mem ||
			    mem_total > w.free_bytes - min_free_mem) begin
				return ral_pkg::ST_MEMORY;
			end
			return ral_pkg::ST_OK;
		endfunction

		// Note an accepted word: update the table and queue the owed result.
		function void note_request(ral_pkg::ral_request_t w);
			ral_pkg::ral_result_t want;
			bit [63:0]            in_use;
			bit [63:0]            cap;
			bit [63:0]            spare;
			want   = '0;
			in_use = '0;
			for (int i = 0; i < ral_pkg::SLOTS; i++) begin
				if (slot_taken[i]) begin
					in_use = sat_sum(in_use, {32'd0, slot_units[i]});
				end
			end
			cap   = alloc_cap();
			spare = cap - in_use;
			op_count[w.operation]++;
			case (w.operation)
				ral_pkg::OP_CHECK: want.status = admit_status(w);
				ral_pkg::OP_ALLOC: begin
					want.status = admit_status(w);
					if (want.status == ral_pkg::ST_OK) begin
						slot_taken[w.slot] = 1'b1;
						slot_units[w.slot] = w.request_units;
						slot_mem[w.slot]   = w.request_memory;
					end
				end
				ral_pkg::OP_RELEASE: begin
					if (w.id_present && w.slot < ral_pkg::SLOTS) begin
						slot_taken[w.slot] = 1'b0;
					end
				end
				ral_pkg::OP_CLEAR: begin
					foreach (slot_taken[i]) begin
						slot_taken[i] = 1'b0;
					end
				end
				ral_pkg::OP_USED: begin
					want.unit_count = (in_use > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF :
						in_use[31:0];
				end
				ral_pkg::OP_AVAIL: begin
					want.unit_count = (cap > in_use) ? spare[31:0] : 32'd0;
				end
				default: ;
			endcase
			owed_q.push_back(want);
		endfunction

		function int pending_count();
			return owed_q.size();
		endfunction

		task report(string what);
			if (mismatches < 50) begin
				$display("MISMATCH at %0t: %s", $realtime, what);
			end
			mismatches++;
		endtask

		// Compare one result word with the oldest owed result.
		task check_result(ral_pkg::ral_result_t got);
			ral_pkg::ral_result_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("result with nothing owed: status %0d count %0d",
					got.status, got.unit_count));
				return;
			end
			want = owed_q.pop_front();
			status_count[got.status]++;
			if (got.status !== want.status) begin
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			end
			if (got.unit_count !== want.unit_count) begin
				report($sformatf("unit_count %0d, expected %0d",
					got.unit_count, want.unit_count));
			end
		endtask
	endclass

	ledger_scoreboard ledger_sb;

	resource_admission_ledger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Every strobed result word is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			ledger_sb.check_result(result);
		end
	end

	function automatic ral_pkg::ral_request_t ledger_word(logic [2:0] op, logic [3:0] slot,
		logic named, logic fps_neg, logic [31:0] units, logic [63:0] mem, logic [63:0] free);
		ral_pkg::ral_request_t w;
		w.operation      = op;
		w.slot           = slot;
		w.id_present     = named;
		w.fps_negative   = fps_neg;
		w.request_units  = units;
		w.request_memory = mem;
		w.free_bytes     = free;
		return w;
	endfunction

	// Mostly well-formed words sized to the current limits; some pure noise.
	function automatic ral_pkg::ral_request_t random_word();
		ral_pkg::ral_request_t w;
		int unsigned           pick;
		bit [63:0]             step;
		pick = $urandom_range(0, 99);
		step = 64'($urandom_range(1, 24));
		if ($urandom_range(0, 99) < 15) begin
			w.operation      = 3'($urandom_range(0, 7));
			w.slot           = 4'($urandom_range(0, 15));
			w.id_present     = 1'($urandom_range(0, 1));
			w.fps_negative   = 1'($urandom_range(0, 1));
			w.request_units  = $urandom;
			w.request_memory = {$urandom, $urandom};
			w.free_bytes     = {$urandom, $urandom};
			return w;
		end
		if (pick < 30) begin
			w.operation = ral_pkg::OP_ALLOC;
		end else if (pick < 55) begin
			w.operation = ral_pkg::OP_CHECK;
		end else if (pick < 72) begin
			w.operation = ral_pkg::OP_RELEASE;
		end else if (pick < 82) begin
			w.operation = ral_pkg::OP_USED;
		end else if (pick < 92) begin
			w.operation = ral_pkg::OP_AVAIL;
		end else if (pick < 95) begin
			w.operation = ral_pkg::OP_CLEAR;
		end else if (pick < 98) begin
			w.operation = OP_SPARE_A;
		end else begin
			w.operation = OP_SPARE_B;
		end
		w.slot           = 4'($urandom_range(0, ral_pkg::SLOTS - 1));
		w.id_present     = ($urandom_range(0, 19) != 0);
		w.fps_negative   = ($urandom_range(0, 19) == 0);
		w.request_units  = $urandom_range(0, unit_span);
		w.request_memory = 64'($urandom_range(0, 1 << 20));
		w.free_bytes     = ($urandom_range(0, 19) == 0) ? 64'd0 :
			phase_min_free + (step << 20);
		return w;
	endfunction

	// Offer one word and hold it until the block takes it.
	task automatic send_word(input ral_pkg::ral_request_t w);
		start   <= 1'b1;
		request <= w;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		ledger_sb.note_request(w);
	endtask

	task automatic hold_off(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop offering words and wait until every owed result has come back.
	task automatic drain_ledger();
		start <= 1'b0;
		@(posedge clk);
		while (ledger_sb.pending_count() != 0 || busy) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] index, input logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		ledger_sb.write_reg(index, value);
	endtask

	// Program all three limits once the block is idle. The 32-bit registers
	// get junk in the upper data bits, which must be ignored.
	task automatic program_limits(input bit [31:0] tot, input bit [31:0] rsv,
		input bit [63:0] mf);
		bit [31:0] cap;
		drain_ledger();
		put_reg(ral_pkg::REG_TOTAL_UNITS, {$urandom, tot});
		put_reg(ral_pkg::REG_RESERVED_UNITS, {$urandom, rsv});
		put_reg(ral_pkg::REG_MIN_FREE_MEM, mf);
		cfg_we <= 1'b0;
		cap            = (tot > rsv) ? tot - rsv : 32'd0;
		unit_span      = cap / 32'd6;
		phase_min_free = mf;
	endtask

	initial begin
		bit [31:0]   tot;
		bit [31:0]   rsv;
		bit [63:0]   mf;
		int unsigned idle_pct;
		ledger_sb   = new();
		cycle_count = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		cfg_we      = 1'b0;
		cfg_index   = ral_pkg::REG_TOTAL_UNITS;
		cfg_data    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: widest limits, invalid requests, full-scale units and
		// memory, memory sum overflow, release without an id, spare codes.
		program_limits(32'hFFFF_FFFF, 32'd0, 64'd0);
		send_word(ledger_word(ral_pkg::OP_CHECK, 4'd0, 1'b0, 1'b0, 32'd5, 64'd5, 64'd100));
		send_word(ledger_word(ral_pkg::OP_ALLOC, 4'd0, 1'b1, 1'b1, 32'd5, 64'd5, 64'd100));
		send_word(ledger_word(ral_pkg::OP_ALLOC, 4'd15, 1'b1, 1'b0, '1, 64'd0, 64'd0));
		send_word(ledger_word(ral_pkg::OP_ALLOC, 4'd0, 1'b1, 1'b0, 32'd1, 64'd0, '1));
		send_word(ledger_word(ral_pkg::OP_USED, 4'd0, 1'b1, 1'b0, 32'd0, 64'd0, 64'd0));
		send_word(ledger_word(ral_pkg::OP_AVAIL, 4'd0, 1'b1, 1'b0, 32'd0, 64'd0, 64'd0));
		send_word(ledger_word(ral_pkg::OP_ALLOC, 4'd15, 1'b1, 1'b0, 32'd0, '1, '1));
		send_word(ledger_word(ral_pkg::OP_CHECK, 4'd3, 1'b1, 1'b0, 32'd0, 64'd1, '1));
		send_word(ledger_word(ral_pkg::OP_RELEASE, 4'd15, 1'b0, 1'b0, 32'd0, 64'd0, 64'd0));
		send_word(ledger_word(ral_pkg::OP_CHECK, 4'd3, 1'b1, 1'b0, 32'd0, 64'd0, '1));
		send_word(ledger_word(ral_pkg::OP_RELEASE, 4'd15, 1'b1, 1'b0, 32'd0, 64'd0, 64'd0));
		send_word(ledger_word(OP_SPARE_A, 4'd15, 1'b1, 1'b1, '1, '1, '1));
		send_word(ledger_word(OP_SPARE_B, 4'd15, 1'b1, 1'b1, '1, '1, '1));
		send_word(ledger_word(ral_pkg::OP_ALLOC, 4'd5, 1'b1, 1'b0, 32'd100, 64'd100,
			64'd1000));
		send_word(ledger_word(ral_pkg::OP_CLEAR, 4'd0, 1'b0, 1'b0, 32'd0, 64'd0, 64'd0));
		send_word(ledger_word(ral_pkg::OP_ALLOC, 4'd15, 1'b1, 1'b0, '1, '1, '1));
		send_word(ledger_word(ral_pkg::OP_ALLOC, 4'd4, 1'b1, 1'b0, 32'd7, 64'd50, 64'd200));

		// Reserved above total leaves nothing to hand out; the words with free
		// memory below the floor fail the compute test first, as slot 15 is taken.
		program_limits(32'd100, 32'd200, '1);
		send_word(ledger_word(ral_pkg::OP_AVAIL, 4'd0, 1'b1, 1'b0, 32'd0, 64'd0, 64'd0));
		send_word(ledger_word(ral_pkg::OP_CHECK, 4'd4, 1'b1, 1'b0, 32'd0, 64'd0, 64'd5));
		send_word(ledger_word(ral_pkg::OP_CHECK, 4'd9, 1'b1, 1'b0, 32'd0, 64'd0, '1));

		// Words close to the bounds of the compute and memory tests.
		program_limits(32'd5000, 32'd1000, 64'd1000);
		send_word(ledger_word(ral_pkg::OP_RELEASE, 4'd15, 1'b1, 1'b0, 32'd0, 64'd0, 64'd0));
		send_word(ledger_word(ral_pkg::OP_CHECK, 4'd1, 1'b1, 1'b0, 32'd10, 64'd10, 64'd999));
		send_word(ledger_word(ral_pkg::OP_CHECK, 4'd1, 1'b1, 1'b0, 32'd3994, 64'd0,
			64'd2000));
		send_word(ledger_word(ral_pkg::OP_CHECK, 4'd1, 1'b1, 1'b0, 32'd3993, 64'd950,
			64'd2000));
		send_word(ledger_word(ral_pkg::OP_AVAIL, 4'd0, 1'b1, 1'b0, 32'd0, 64'd0, 64'd0));

		// Random phases, each under its own limits and sender idling.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					tot = $urandom_range(1000, 1000000);
					rsv = $urandom_range(0, 500);
					mf  = 64'($urandom_range(0, 1 << 24));
					idle_pct = 0;
				end
				1: begin
					tot = $urandom_range(1000, 1000000);
					rsv = $urandom_range(0, 500);
					mf  = 64'($urandom_range(0, 1 << 24));
					idle_pct = 61;
				end
				2: begin
					tot = '1;
					rsv = '0;
					mf  = '0;
					idle_pct = 30;
				end
				3: begin
					tot = $urandom;
					rsv = $urandom;
					mf  = {$urandom, $urandom};
					idle_pct = 61;
				end
				4: begin
					tot = '0;
					rsv = '1;
					mf  = '1;
					idle_pct = 30;
				end
				default: begin
					tot = $urandom_range(16, 4096);
					rsv = $urandom_range(0, 15);
					mf  = '0;
					idle_pct = 0;
				end
			endcase
			program_limits(tot, rsv, mf);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Halfway through, let the block run completely dry once.
				if (n == ITEMS_PER_PHASE / 2) begin
					drain_ledger();
				end
				send_word(random_word());
				if ($urandom_range(0, 99) < idle_pct) begin
					hold_off($urandom_range(1, 24));
				end
			end
		end

		drain_ledger();
		repeat (ral_pkg::SLOTS + 8) @(posedge clk);
		$display("Words: check %0d, allocate %0d, release %0d, clear %0d, used %0d,",
			ledger_sb.op_count[ral_pkg::OP_CHECK], ledger_sb.op_count[ral_pkg::OP_ALLOC],
			ledger_sb.op_count[ral_pkg::OP_RELEASE], ledger_sb.op_count[ral_pkg::OP_CLEAR],
			ledger_sb.op_count[ral_pkg::OP_USED]);
		$display("  available %0d, spare %0d; results ok %0d, invalid %0d, compute %0d,",
			ledger_sb.op_count[ral_pkg::OP_AVAIL],
			ledger_sb.op_count[OP_SPARE_A] + ledger_sb.op_count[OP_SPARE_B],
			ledger_sb.status_count[ral_pkg::ST_OK],
			ledger_sb.status_count[ral_pkg::ST_INVALID],
			ledger_sb.status_count[ral_pkg::ST_COMPUTE]);
		$display("  memory %0d; mismatches %0d",
			ledger_sb.status_count[ral_pkg::ST_MEMORY], ledger_sb.mismatches);
		if (ledger_sb.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[resource_admission_ledger.f]
design/ral_pkg.sv
design/ral_ctrl.sv
design/ral_dpath.sv
design/resource_admission_ledger.sv
test/tb_resource_admission_ledger.sv
